>>> sv/ovor_pkg.sv
// ----------------------------------------------------------------------------
// ovor_pkg: shared types and constants
// Beat layouts, register indexes, mark codes and volume geometry for the
// octree voxel occupancy refine unit.
// ----------------------------------------------------------------------------
package ovor_pkg;

    // Volume geometry: one memory row holds all z voxels of one (x, y) column
    localparam int VOL_BITS   = 6;
    localparam int SIDE       = 1 << VOL_BITS;
    localparam int ROW_DEPTH  = SIDE * SIDE;
    localparam int ROW_AW     = 2 * VOL_BITS;
    localparam int COORD_BITS = 19;
    localparam int LVL_W      = 3;
    localparam int CFG_IDX_W  = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FINEST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWEST = 1'b1;

    // Reset values of the configuration registers
    localparam logic [LVL_W-1:0] FINEST_RST = 3'd6;
    localparam logic [LVL_W-1:0] LOWEST_RST = 3'd0;

    // Item functions
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Mark codes
    localparam logic [1:0] MARK_NONE     = 2'd0;
    localparam logic [1:0] MARK_UNMARKED = 2'd1;
    localparam logic [1:0] MARK_MARKED   = 2'd2;
    localparam logic [1:0] MARK_BAD      = 2'd3;

    typedef struct packed {
        logic        func;
        logic [5:0]  voxel_x;
        logic [5:0]  voxel_y;
        logic [5:0]  voxel_z;
        logic        voxel_bit;
        logic [18:0] octant_x;
        logic [18:0] octant_y;
        logic [18:0] octant_z;
        logic [4:0]  octant_level;
    } in_item_t;

    typedef struct packed {
        logic       refine;
        logic [1:0] mark;
        logic       out_of_volume;
    } out_item_t;

    typedef struct packed {
        logic [LVL_W-1:0] finest;
        logic [LVL_W-1:0] lowest;
    } cfg_t;

    // Sequencer to row memory
    typedef struct packed {
        logic              we;
        logic [ROW_AW-1:0] addr;
        logic [SIDE-1:0]   wdata;
    } mem_req_t;

    // Sequencer result toward the output register
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } seq_res_t;

endpackage

>>> sv/ovor_ram.sv
// ----------------------------------------------------------------------------
// ovor_ram: generic single-port RAM
// One read or write per cycle, registered read data, no reset on contents.
// ----------------------------------------------------------------------------
module ovor_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> sv/ovor_seq.sv
// ----------------------------------------------------------------------------
// ovor_seq: item sequencer
// Runs voxel writes as read-modify-write of one row, and queries as a level
// and clip step, then if needed a row-by-row scan through one masked row test.
// ----------------------------------------------------------------------------
module ovor_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  ovor_pkg::in_item_t     in_item,
    input  ovor_pkg::cfg_t         cfg,
    input  logic [ovor_pkg::SIDE-1:0] rd_data,
    input  logic                   take,
    output ovor_pkg::mem_req_t     mem_req,
    output ovor_pkg::seq_res_t     res,
    output logic                   idle
);
    import ovor_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_TEST  = 3'd3;
    localparam logic [2:0] S_WREAD = 3'd4;
    localparam logic [2:0] S_WMOD  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    typedef struct packed {
        logic                in_vol;
        logic                beyond;
        logic [VOL_BITS-1:0] lo;
        logic [VOL_BITS-1:0] hi;
    } axis_t;

    // Corner to voxel range on one axis, clipped to the volume
    function automatic axis_t clip(input logic [COORD_BITS-1:0] o,
                                   input logic [4:0] shift,
                                   input logic [7:0] tile);
        logic [COORD_BITS-1:0] c0;
        logic [COORD_BITS:0]   last;
        axis_t                 a;
        c0       = o >> shift;
        last     = {1'b0, c0} + {{(COORD_BITS-7){1'b0}}, tile} - 1'b1;
        a.in_vol = c0 < COORD_BITS'(SIDE);
        a.beyond = last >= (COORD_BITS+1)'(SIDE);
        a.lo     = c0[VOL_BITS-1:0];
        a.hi     = a.beyond ? VOL_BITS'(SIDE-1) : last[VOL_BITS-1:0];
        return a;
    endfunction

    logic [2:0]          state_reg, state_next;
    in_item_t            item_reg, item_next;
    logic [VOL_BITS-1:0] x_reg, x_next;
    logic [VOL_BITS-1:0] y_reg, y_next;
    logic [VOL_BITS-1:0] ylo_reg, ylo_next;
    logic [VOL_BITS-1:0] xhi_reg, xhi_next;
    logic [VOL_BITS-1:0] yhi_reg, yhi_next;
    logic [SIDE-1:0]     zmask_reg, zmask_next;
    logic                oov_reg, oov_next;
    logic                single_reg, single_next;
    out_item_t           res_reg, res_next;

    logic [4:0]          shift;
    logic [LVL_W-1:0]    tile_log;
    logic [7:0]          tile;
    axis_t               ax, ay, az;
    logic                lvl_above, lvl_below;
    logic                row_hit;
    logic                wr_in_vol;
    logic [SIDE-1:0]     merged;

    // Clip arithmetic for the held query
    always_comb
    begin
        shift     = 5'(COORD_BITS) - {2'b00, cfg.finest};
        tile_log  = cfg.finest - item_reg.octant_level[LVL_W-1:0];
        tile      = 8'd1 << tile_log;
        ax        = clip(item_reg.octant_x, shift, tile);
        ay        = clip(item_reg.octant_y, shift, tile);
        az        = clip(item_reg.octant_z, shift, tile);
        lvl_above = item_reg.octant_level > {2'b00, cfg.finest};
        lvl_below = item_reg.octant_level < {2'b00, cfg.lowest};
    end

    // Shared row test and write merge
    always_comb
    begin
        row_hit   = |(rd_data & zmask_reg);
        wr_in_vol = ({1'b0, item_reg.voxel_x} < 7'(SIDE)) &&
                    ({1'b0, item_reg.voxel_y} < 7'(SIDE)) &&
                    ({1'b0, item_reg.voxel_z} < 7'(SIDE));
        merged    = rd_data;
        merged[item_reg.voxel_z[VOL_BITS-1:0]] = item_reg.voxel_bit;
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        ylo_next    = ylo_reg;
        xhi_next    = xhi_reg;
        yhi_next    = yhi_reg;
        zmask_next  = zmask_reg;
        oov_next    = oov_reg;
        single_next = single_reg;
        res_next    = res_reg;
        mem_req.we    = 1'b0;
        mem_req.addr  = {x_reg, y_reg};
        mem_req.wdata = merged;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next  = in_item;
                    state_next = (in_item.func == FUNC_WRITE) ? S_WREAD : S_SETUP;
                end
            end
            S_WREAD:
            begin
                mem_req.addr = {item_reg.voxel_x[VOL_BITS-1:0],
                                item_reg.voxel_y[VOL_BITS-1:0]};
                state_next   = S_WMOD;
            end
            S_WMOD:
            begin
                mem_req.addr = {item_reg.voxel_x[VOL_BITS-1:0],
                                item_reg.voxel_y[VOL_BITS-1:0]};
                mem_req.we   = wr_in_vol;
                res_next     = '{refine: 1'b0, mark: MARK_NONE, out_of_volume: 1'b0};
                state_next   = S_DONE;
            end
            S_SETUP:
            begin
                if (lvl_above)
                begin
                    res_next   = '{refine: 1'b0, mark: MARK_NONE, out_of_volume: 1'b0};
                    state_next = S_DONE;
                end
                else if (lvl_below)
                begin
                    res_next   = '{refine: 1'b1, mark: MARK_NONE, out_of_volume: 1'b0};
                    state_next = S_DONE;
                end
                else if (!(ax.in_vol && ay.in_vol && az.in_vol))
                begin
                    res_next   = '{refine: 1'b0, mark: MARK_UNMARKED,
                                   out_of_volume: ax.beyond | ay.beyond | az.beyond};
                    state_next = S_DONE;
                end
                else
                begin
                    x_next      = ax.lo;
                    y_next      = ay.lo;
                    ylo_next    = ay.lo;
                    xhi_next    = ax.hi;
                    yhi_next    = ay.hi;
                    zmask_next  = ({SIDE{1'b1}} << az.lo) & ({SIDE{1'b1}} >> (~az.hi));
                    oov_next    = ax.beyond | ay.beyond | az.beyond;
                    single_next = (tile_log == '0);
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (row_hit)
                begin
                    res_next   = single_reg ?
                        out_item_t'{refine: 1'b0, mark: MARK_MARKED, out_of_volume: oov_reg} :
                        out_item_t'{refine: 1'b1, mark: MARK_NONE, out_of_volume: oov_reg};
                    state_next = S_DONE;
                end
                else if (y_reg != yhi_reg)
                begin
                    y_next     = y_reg + 1'b1;
                    state_next = S_READ;
                end
                else if (x_reg != xhi_reg)
                begin
                    x_next     = x_reg + 1'b1;
                    y_next     = ylo_reg;
                    state_next = S_READ;
                end
                else
                begin
                    res_next   = '{refine: 1'b0, mark: MARK_UNMARKED,
                                   out_of_volume: oov_reg};
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        ylo_reg    <= ylo_next;
        xhi_reg    <= xhi_next;
        yhi_reg    <= yhi_next;
        zmask_reg  <= zmask_next;
        oov_reg    <= oov_next;
        single_reg <= single_next;
        res_reg    <= res_next;
    end

    assign res.valid = (state_reg == S_DONE);
    assign res.item  = res_reg;
    assign idle      = (state_reg == S_IDLE);

endmodule

>>> sv/octree_voxel_occupancy_refine_unit.sv
// ----------------------------------------------------------------------------
// octree_voxel_occupancy_refine_unit: octant refinement from voxel occupancy
// Holds a 64x64x64 occupancy volume and answers octant refine queries.
// ----------------------------------------------------------------------------
//  channel | signals                          | beat
//  --------+----------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_data      | one voxel write or octant query
//  out     | out_valid, out_ready, out_data   | refine, mark, out_of_volume
//  cfg     | cfg_we, cfg_index, cfg_data      | finest_level / lowest_level
//
//  A voxel write runs a row read, a merge and a write back before its result
//  goes to the output register. A query is decided by level or clipping in
//  its setup step, else by a scan of one 64-voxel z row per memory read, up
//  to 4096 rows, so the single-port row memory sets the rate. The unit goes
//  back to idle once its result is taken, and only then accepts a new beat.
//  No clearing pass after reset; volume contents are undefined until written.
//  A new beat is accepted once the previous result sits in the output
//  register, even while out_ready is low.
// ----------------------------------------------------------------------------
module octree_voxel_occupancy_refine_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  ovor_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output ovor_pkg::out_item_t               out_data,
    input  logic                              cfg_we,
    input  logic [ovor_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ovor_pkg::LVL_W-1:0]        cfg_data
);
    import ovor_pkg::*;

    cfg_t            cfg_reg;
    logic            out_valid_reg;
    out_item_t       out_data_reg;
    mem_req_t        mem_req;
    logic [SIDE-1:0] rd_data;
    seq_res_t        res;
    logic            idle;
    logic            take;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.finest <= FINEST_RST;
            cfg_reg.lowest <= LOWEST_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FINEST: cfg_reg.finest <= cfg_data;
                CFG_LOWEST: cfg_reg.lowest <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Row memory: address {x, y}, bit z
    ovor_ram #(
        .WIDTH (SIDE),
        .DEPTH (ROW_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (rd_data)
    );

    ovor_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (in_valid && in_ready),
        .in_item (in_data),
        .cfg     (cfg_reg),
        .rd_data (rd_data),
        .take    (take),
        .mem_req (mem_req),
        .res     (res),
        .idle    (idle)
    );

    assign in_ready = idle;
    assign take     = res.valid && (!out_valid_reg || out_ready);

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= res.item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> sv/ovor_checker.sv
// ----------------------------------------------------------------------------
// ovor_checker: port-level checks
// Tracks beats in flight and checks result coding and output stalls.
// ----------------------------------------------------------------------------
module ovor_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input ovor_pkg::out_item_t            out_data
);
    import ovor_pkg::*;

    logic [1:0] pend_reg;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    // Beats accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
        end
        else
        begin
            pend_reg <= pend_reg + {1'b0, in_beat} - {1'b0, out_beat};
        end
    end

    // No result without a beat behind it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result beat with no pending input beat");

    // While ready for input, at most the waiting result is in flight
    a_ready_depth: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> pend_reg <= 2'd1)
        else $error("input ready while an item is still in work");

    // An accepted beat leaves the unit busy in the cycle after it
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !in_ready)
        else $error("input ready right after an accepted beat");

    // Refine only with unchanged mark, never the unused mark code
    a_coding: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.mark != MARK_BAD) &&
                      (!out_data.refine || out_data.mark == MARK_NONE))
        else $error("illegal refine/mark combination");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed");

endmodule

bind octree_voxel_occupancy_refine_unit ovor_checker u_ovor_checker (.*);

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for octree_voxel_occupancy_refine_unit
// Clears two cubes of the volume, runs a directed set of writes and queries,
// then random phases over several level settings. A scoreboard class keeps
// its own occupancy volume, predicts each result beat and checks it in order.
// ----------------------------------------------------------------------------
module tb;

    import ovor_pkg::*;

    localparam int VOXELS        = SIDE * ROW_DEPTH;
    localparam int LOW_SIDE      = 8;         // cleared cube [0, 7]^3
    localparam int HIGH_BASE     = SIDE - 4;  // cleared cube [60, 63]^3
    localparam int PHASES        = 10;
    localparam int PER_PHASE     = 100;
    localparam int SETTLE_CYCLES = 16;
    localparam int LIMIT_NS      = 100_000_000;

    // Occupancy predictor and queue of decisions still owed by the block
    class occupancy_scoreboard;
        bit        occupied [0:VOXELS-1];
        int        occupied_total;
        int        finest;
        int        lowest;
        int        mismatches;
        out_item_t decisions_due [$];

        function new();
            occupied_total = 0;
            finest         = FINEST_RST;
            lowest         = LOWEST_RST;
            mismatches     = 0;
        endfunction

        function void set_levels(input int f, input int lo);
            finest = f;
            lowest = lo;
        endfunction

        // Apply one beat to the volume and work out its result
        function out_item_t refine_decision(input in_item_t it);
            out_item_t   r;
            logic [17:0] vox;
            logic [18:0] crd [3];
            int          shift, tile, c0, last, a, x, y, z;
            int          lo_c [3];
            int          hi_c [3];
            bit          spills, clipped, hit;
            r = '0;
            if (it.func == FUNC_WRITE)
            begin
                vox = {it.voxel_x, it.voxel_y, it.voxel_z};
                if (it.voxel_bit && !occupied[vox])
                begin
                    occupied[vox] = 1'b1;
                    occupied_total++;
                end
                else if (!it.voxel_bit && occupied[vox])
                begin
                    occupied[vox] = 1'b0;
                    occupied_total--;
                end
                return r;
            end
            // decided by level alone
            if (it.octant_level > finest)
                return r;
            if (it.octant_level < lowest)
            begin
                r.refine = 1'b1;
                return r;
            end
            // clip the octant cube to the volume, axis by axis
            shift   = COORD_BITS - finest;
            tile    = 1 << (finest - it.octant_level);
            crd[0]  = it.octant_x;
            crd[1]  = it.octant_y;
            crd[2]  = it.octant_z;
            spills  = 1'b0;
            clipped = 1'b0;
            hit     = 1'b0;
            for (a = 0; a < 3; a++)
            begin
                c0   = int'(crd[a] >> shift);
                last = c0 + tile - 1;
                if (last >= SIDE)
                    spills = 1'b1;
                if (c0 >= SIDE)
                    clipped = 1'b1;
                lo_c[a] = c0;
                hi_c[a] = (last < SIDE) ? last : SIDE - 1;
            end
            if (!clipped && occupied_total != 0)
            begin
                for (x = lo_c[0]; x <= hi_c[0] && !hit; x++)
                    for (y = lo_c[1]; y <= hi_c[1] && !hit; y++)
                        for (z = lo_c[2]; z <= hi_c[2] && !hit; z++)
                            if (occupied[x * ROW_DEPTH + y * SIDE + z])
                                hit = 1'b1;
            end
            r.out_of_volume = spills;
            if (!hit)
                r.mark = MARK_UNMARKED;
            else if (tile == 1)
                r.mark = MARK_MARKED;
            else
                r.refine = 1'b1;
            return r;
        endfunction

        function void note_beat(input in_item_t it);
            decisions_due.push_back(refine_decision(it));
        endfunction

        function void check_beat(input out_item_t got);
            out_item_t want;
            if (decisions_due.size() == 0)
            begin
                $display("%0t: result beat with nothing owed, actual %b", $time, got);
                mismatches++;
                return;
            end
            want = decisions_due.pop_front();
            if (got.refine !== want.refine)
            begin
                $display("%0t: refine expected %0d actual %0d", $time, want.refine, got.refine);
                mismatches++;
            end
            if (got.mark !== want.mark)
            begin
                $display("%0t: mark expected %0d actual %0d", $time, want.mark, got.mark);
                mismatches++;
            end
            if (got.out_of_volume !== want.out_of_volume)
            begin
                $display("%0t: out_of_volume expected %0d actual %0d", $time,
                         want.out_of_volume, got.out_of_volume);
                mismatches++;
            end
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_item_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_FINEST;
    logic [LVL_W-1:0]     cfg_data  = '0;

    occupancy_scoreboard sb = new();

    int cur_finest = FINEST_RST;
    int cur_lowest = LOWEST_RST;
    int gap_pct    = 0;
    int stall_pct  = 0;
    int ready_left = 0;
    int hot_x      = 0;
    int hot_y      = 0;
    int hot_z      = 0;

    int finest_plan [PHASES] = '{3, 2, 7, 0, 6, 5, 7, 1, 4, 6};
    int lowest_plan [PHASES] = '{0, 1, 0, 0, 6, 2, 7, 3, 0, 0};

    octree_voxel_occupancy_refine_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: check accepted beats, stall out_ready in bursts
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_beat(out_data);
        if (ready_left == 0)
        begin
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                out_ready  <= 1'b0;
                ready_left = $urandom_range(1, 11);
            end
            else
            begin
                out_ready  <= 1'b1;
                ready_left = $urandom_range(1, 16);
            end
        end
        ready_left = ready_left - 1;
    end

    // Beat with every field random
    function automatic in_item_t random_fill();
        in_item_t it;
        it.func         = 1'($urandom_range(0, 1));
        it.voxel_x      = 6'($urandom);
        it.voxel_y      = 6'($urandom);
        it.voxel_z      = 6'($urandom);
        it.voxel_bit    = 1'($urandom);
        it.octant_x     = 19'($urandom);
        it.octant_y     = 19'($urandom);
        it.octant_z     = 19'($urandom);
        it.octant_level = 5'($urandom_range(0, 19));
        return it;
    endfunction

    function automatic in_item_t write_item(input int x, input int y, input int z,
                                            input bit occ);
        in_item_t it;
        it           = random_fill();
        it.func      = FUNC_WRITE;
        it.voxel_x   = 6'(x);
        it.voxel_y   = 6'(y);
        it.voxel_z   = 6'(z);
        it.voxel_bit = occ;
        return it;
    endfunction

    function automatic in_item_t query_item(input logic [18:0] x, input logic [18:0] y,
                                            input logic [18:0] z, input int lvl);
        in_item_t it;
        it              = random_fill();
        it.func         = FUNC_QUERY;
        it.octant_x     = x;
        it.octant_y     = y;
        it.octant_z     = z;
        it.octant_level = 5'(lvl);
        return it;
    endfunction

    // Corner coordinate of a voxel index, with random sub-voxel bits
    function automatic logic [18:0] at_voxel(input int idx);
        int shift;
        shift = COORD_BITS - cur_finest;
        return 19'((idx << shift) | ($urandom & ((1 << shift) - 1)));
    endfunction

    // Zone 0: cleared low cube, 1: cleared high cube (or beyond), 2: anywhere
    function automatic logic [18:0] axis_coord(input int zone);
        int top, idx;
        top = (1 << cur_finest) - 1;
        if (zone == 2)
            return 19'($urandom);
        if (zone == 1 && top >= HIGH_BASE)
            idx = $urandom_range(HIGH_BASE, top);
        else
            idx = $urandom_range(0, (top < LOW_SIDE - 1) ? top : LOW_SIDE - 1);
        return at_voxel(idx);
    endfunction

    // True when the query scans nothing or only voxels inside a cleared cube
    function automatic bit scan_fits_written(input in_item_t it);
        logic [18:0] crd [3];
        int          shift, tile, c0, hi, a;
        bit          in_low, in_high;
        if (it.octant_level > cur_finest || it.octant_level < cur_lowest)
            return 1'b1;
        shift   = COORD_BITS - cur_finest;
        tile    = 1 << (cur_finest - it.octant_level);
        crd[0]  = it.octant_x;
        crd[1]  = it.octant_y;
        crd[2]  = it.octant_z;
        in_low  = 1'b1;
        in_high = 1'b1;
        for (a = 0; a < 3; a++)
        begin
            c0 = int'(crd[a] >> shift);
            if (c0 >= SIDE)
                return 1'b1;
            hi = c0 + tile - 1;
            if (hi > SIDE - 1)
                hi = SIDE - 1;
            if (hi >= LOW_SIDE)
                in_low = 1'b0;
            if (c0 < HIGH_BASE)
                in_high = 1'b0;
        end
        return in_low || in_high;
    endfunction

    // Write biased toward a small dense corner so that leaves get marked
    function automatic in_item_t random_write();
        in_item_t it;
        int       zone, lo, hi;
        zone = $urandom_range(0, 9);
        if (zone < 4)
        begin
            lo = 0;
            hi = 3;
        end
        else if (zone < 6)
        begin
            lo = 0;
            hi = LOW_SIDE - 1;
        end
        else if (zone < 8)
        begin
            lo = HIGH_BASE;
            hi = SIDE - 1;
        end
        else
        begin
            lo = 0;
            hi = SIDE - 1;
        end
        it = write_item($urandom_range(lo, hi), $urandom_range(lo, hi),
                        $urandom_range(lo, hi), 1'($urandom_range(0, 1)));
        if (it.voxel_bit)
        begin
            hot_x = it.voxel_x;
            hot_y = it.voxel_y;
            hot_z = it.voxel_z;
        end
        return it;
    endfunction

    // Query that never scans an unwritten voxel; falls back to a level decision
    function automatic in_item_t random_query();
        in_item_t it;
        int       tries, zone, top, span;
        top  = (1 << cur_finest) - 1;
        span = (cur_finest < 4) ? cur_finest : 4;
        for (tries = 0; tries < 32; tries++)
        begin
            zone = $urandom_range(0, 9);
            if (zone < 3 && hot_x <= top && hot_y <= top && hot_z <= top)
                it = query_item(at_voxel(hot_x), at_voxel(hot_y), at_voxel(hot_z),
                                cur_finest);
            else
            begin
                zone = (zone < 6) ? 0 : (zone < 9) ? 1 : 2;
                it = query_item(axis_coord(zone), axis_coord(zone), axis_coord(zone),
                                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19)
                                    : cur_finest - $urandom_range(0, span));
            end
            if (scan_fits_written(it))
                return it;
        end
        it.octant_level = 5'($urandom_range(cur_finest + 1, 19));
        return it;
    endfunction

    // Drive one beat, with a random idle burst ahead of it
    task automatic send_beat(input in_item_t it);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_beat(it);
    endtask

    // Stop sending and wait for every owed result, then a short settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.decisions_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_levels(input int finest, input int lowest);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FINEST;
        cfg_data  <= finest[LVL_W-1:0];
        @(posedge clk);
        cfg_index <= CFG_LOWEST;
        cfg_data  <= lowest[LVL_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_levels(finest, lowest);
        cur_finest = finest;
        cur_lowest = lowest;
    endtask

    task automatic clear_cube(input int base, input int side);
        int x, y, z;
        for (x = 0; x < side; x++)
            for (y = 0; y < side; y++)
                for (z = 0; z < side; z++)
                    send_beat(write_item(base + x, base + y, base + z, 1'b0));
    endtask

    // Main sequence
    initial
    begin : stimulus
        int p, n;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        gap_pct   = 25;
        stall_pct = 25;

        // every voxel a query may scan gets written first
        clear_cube(0, LOW_SIDE);
        clear_cube(HIGH_BASE, SIDE - HIGH_BASE);

        // directed: reset levels, empty volume first
        send_beat(query_item(at_voxel(0), at_voxel(0), at_voxel(0), 7));
        send_beat(query_item(19'h7FFFF, 19'h7FFFF, 19'h7FFFF, 19));
        send_beat(query_item(19'h7FFFF, 19'h7FFFF, 19'h7FFFF, 6));
        send_beat(query_item(at_voxel(62), at_voxel(62), at_voxel(62), 3));
        send_beat(query_item(at_voxel(0), at_voxel(0), at_voxel(0), 6));
        send_beat(write_item(0, 0, 0, 1'b1));
        send_beat(write_item(SIDE - 1, SIDE - 1, SIDE - 1, 1'b1));
        send_beat(write_item(5, 6, 3, 1'b1));
        send_beat(query_item(19'h0, 19'h0, 19'h0, 6));
        send_beat(query_item(19'h7FFFF, 19'h7FFFF, 19'h7FFFF, 6));
        send_beat(query_item(at_voxel(0), at_voxel(0), at_voxel(0), 3));
        send_beat(query_item(at_voxel(62), at_voxel(62), at_voxel(62), 5));
        send_beat(query_item(at_voxel(60), at_voxel(60), at_voxel(60), 4));
        send_beat(query_item(at_voxel(60), at_voxel(60), at_voxel(60), 2));
        send_beat(write_item(5, 6, 3, 1'b0));
        send_beat(write_item(5, 6, 3, 1'b0));
        send_beat(query_item(at_voxel(4), at_voxel(4), at_voxel(0), 4));
        send_beat(write_item(0, 0, 0, 1'b0));
        send_beat(write_item(SIDE - 1, SIDE - 1, SIDE - 1, 1'b0));
        send_beat(query_item(at_voxel(0), at_voxel(0), at_voxel(0), 3));
        send_beat(query_item(at_voxel(1), at_voxel(2), at_voxel(3), 6));

        // random phases over level settings; the last one runs without idling
        for (p = 0; p < PHASES; p++)
        begin
            write_levels(finest_plan[p], lowest_plan[p]);
            if (p == PHASES - 1)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = 25 * $urandom_range(0, 2);
                stall_pct = 25 * $urandom_range(0, 2);
            end
            for (n = 0; n < PER_PHASE; n++)
            begin
                if ($urandom_range(0, 99) < 35)
                    send_beat(random_write());
                else
                    send_beat(random_query());
            end
        end

        drain_results();
        if (sb.mismatches == 0 && sb.decisions_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Hang guard
    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("FAIL");
        $finish;
    end

endmodule
